[design/sca_pkg.sv]
package sca_pkg;

    localparam int unsigned DEFAULT_ENTRIES = 4096;

    localparam int unsigned TOTAL_W  = 20;
    localparam int unsigned MAP_W    = 14;
    localparam int unsigned SECTOR_W = 20;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned BASE_W   = 15;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 20'd4130;
    localparam logic [MAP_W-1:0]   MAP_RESET   = 14'd32;

    // request codes
    localparam logic [2:0] REQ_FORMAT   = 3'd0;
    localparam logic [2:0] REQ_ALLOCATE = 3'd1;
    localparam logic [2:0] REQ_FREE     = 3'd2;
    localparam logic [2:0] REQ_NEXT     = 3'd3;
    localparam logic [2:0] REQ_MARK_END = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    // register indexes
    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_MAP   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC_RD,
        S_NEXT_RD,
        S_FMT,
        S_OUT
    } t_state;

endpackage

[design/sector_chain_allocator_core.sv]
// Linked sector allocation table with a free-sector chain.
// Request channel: i_valid/o_ready carry i_req_type and i_sector; a transaction
// happens when both are high. Result channel: o_valid/i_ready carry
// o_result_sector, o_is_end, o_status and o_free_left, one result per request.
// Registers (APB, byte address 0: total_sectors, 4: map_sectors) must be written
// only while the block is idle; the block itself does not enforce this.
// Steps from acceptance to o_valid: decode and the output stage for free, mark
// end, unused codes, out-of-range requests and allocate with no free sector;
// allocate and next add one registered read of the table memory; format adds
// the write of all D table entries, D = number of data sectors, one entry per
// cycle through the single write port. o_ready is high only in the idle state,
// so a new request is taken no earlier than the cycle after the previous result
// is loaded into the output register; no request is taken while one is in flight.
// The output register holds a result until taken; while it is full the next
// request may still be accepted and processed, and its result waits
// internally until the output register frees up.
// Reset (synchronous, active low) empties the free chain and loads the
// register defaults. The table itself is not cleared: entries are undefined
// until a format writes them.
module sector_chain_allocator_core
    import sca_pkg::*;
#(
    parameter int unsigned ENTRIES = DEFAULT_ENTRIES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_req_type,
    input  logic [SECTOR_W-1:0] i_sector,

    output logic                o_valid,
    input  logic                i_ready,
    output logic [SECTOR_W-1:0] o_result_sector,
    output logic                o_is_end,
    output logic [1:0]          o_status,
    output logic [COUNT_W-1:0]  o_free_left,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned EW = IW + 1;
    localparam int unsigned DW = $clog2(ENTRIES + 1);
    localparam int unsigned CW = (DW > COUNT_W) ? DW : COUNT_W;

    localparam logic [EW-1:0] END_MARK = '1;
    localparam logic [EW-1:0] ENT_EW   = EW'(ENTRIES);
    localparam logic [20:0]   ENT_21   = 21'(ENTRIES);

    // configuration
    logic [TOTAL_W-1:0] r_total;
    logic [MAP_W-1:0]   r_map;

    // derived geometry, refreshed every cycle
    logic [BASE_W-1:0] r_base;
    logic [DW-1:0]     r_data_cnt;
    logic [BASE_W-1:0] base_c;
    logic [20:0]       span_c;
    logic [DW-1:0]     data_cnt_c;

    // control
    t_state              r_state, n_state;
    logic [EW-1:0]       r_head, n_head;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_out_valid, n_out_valid;

    // request and pending result
    logic [2:0]          r_req;
    logic [SECTOR_W-1:0] r_sector;
    logic [IW-1:0]       r_idx, n_idx;
    logic [SECTOR_W-1:0] r_res_sector, n_res_sector;
    logic                r_res_end, n_res_end;
    logic [1:0]          r_res_status, n_res_status;
    logic                load_out;

    // output register
    logic [SECTOR_W-1:0] r_out_sector;
    logic                r_out_end;
    logic [1:0]          r_out_status;
    logic [COUNT_W-1:0]  r_out_free;

    // table memory
    logic [EW-1:0] r_mem [ENTRIES];
    logic [EW-1:0] r_rdata;
    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;

    // decode helpers
    logic [20:0]   rel_diff;
    logic          in_range;
    logic [IW-1:0] rel;
    logic [DW-1:0] idx_next;

    wire cfg_wr = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAP) ? {18'd0, r_map} : {12'd0, r_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_RESET;
            r_map   <= MAP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MAP) begin
                r_map <= pwdata[MAP_W-1:0];
            end else begin
                r_total <= pwdata[TOTAL_W-1:0];
            end
        end
    end

    always_comb begin
        base_c = BASE_W'(r_map) + BASE_W'(2);
        span_c = 21'(r_total) - 21'(base_c);
        if (span_c[20]) begin
            data_cnt_c = '0;
        end else if (span_c > ENT_21) begin
            data_cnt_c = DW'(ENTRIES);
        end else begin
            data_cnt_c = span_c[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= base_c;
        r_data_cnt <= data_cnt_c;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign rel_diff = 21'(r_sector) - 21'(r_base);
    assign in_range = !rel_diff[20] && (rel_diff[19:0] < 20'(r_data_cnt));
    assign rel      = rel_diff[IW-1:0];
    assign idx_next = DW'(r_idx) + DW'(1);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_idx        = r_idx;
        n_res_sector = r_res_sector;
        n_res_end    = r_res_end;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        load_out     = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = rel;
        mem_raddr    = rel;
        mem_wdata    = END_MARK;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_sector = '0;
                n_res_end    = 1'b0;
                n_res_status = ST_OK;
                n_state      = S_OUT;
                case (r_req)
                    REQ_FORMAT: begin
                        n_idx = '0;
                        if (r_data_cnt == '0) begin
                            n_head  = END_MARK;
                            n_count = '0;
                        end else begin
                            n_state = S_FMT;
                        end
                    end
                    REQ_ALLOCATE: begin
                        if (r_head >= ENT_EW) begin
                            n_res_status = ST_NO_FREE;
                            n_res_end    = 1'b1;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = r_head[IW-1:0];
                            n_state   = S_ALLOC_RD;
                        end
                    end
                    REQ_FREE, REQ_NEXT, REQ_MARK_END: begin
                        if (!in_range) begin
                            n_res_status = ST_RANGE;
                            n_res_end    = 1'b1;
                        end else if (r_req == REQ_FREE) begin
                            mem_we    = 1'b1;
                            mem_wdata = r_head;
                            n_head    = EW'(rel);
                            if (r_count != COUNT_MAX) begin
                                n_count = r_count + COUNT_W'(1);
                            end
                        end else if (r_req == REQ_NEXT) begin
                            mem_re  = 1'b1;
                            n_state = S_NEXT_RD;
                        end else begin
                            mem_we = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ALLOC_RD: begin
                n_head    = (r_rdata >= ENT_EW) ? END_MARK : r_rdata;
                mem_we    = 1'b1;
                mem_waddr = r_head[IW-1:0];
                if (r_count != '0) begin
                    n_count = r_count - COUNT_W'(1);
                end
                n_res_sector = SECTOR_W'(r_head[IW-1:0]) + SECTOR_W'(r_base);
                n_state      = S_OUT;
            end
            S_NEXT_RD: begin
                if (r_rdata >= ENT_EW) begin
                    n_res_end = 1'b1;
                end else begin
                    n_res_sector = SECTOR_W'(r_rdata[IW-1:0]) + SECTOR_W'(r_base);
                end
                n_state = S_OUT;
            end
            S_FMT: begin
                // one entry per cycle, each pointing at the next one, the last at the end mark
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                if (idx_next < r_data_cnt) begin
                    mem_wdata = EW'(idx_next);
                    n_idx     = r_idx + IW'(1);
                end else begin
                    n_head  = '0;
                    n_count = (CW'(r_data_cnt) > CW'(COUNT_MAX)) ? COUNT_MAX
                                                                 : COUNT_W'(r_data_cnt);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= END_MARK;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_req    <= i_req_type;
            r_sector <= i_sector;
        end
        r_idx        <= n_idx;
        r_res_sector <= n_res_sector;
        r_res_end    <= n_res_end;
        r_res_status <= n_res_status;
        if (load_out) begin
            r_out_sector <= r_res_sector;
            r_out_end    <= r_res_end;
            r_out_status <= r_res_status;
            r_out_free   <= r_count;
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_result_sector = r_out_sector;
    assign o_is_end        = r_out_end;
    assign o_status        = r_out_status;
    assign o_free_left     = r_out_free;

endmodule

[tb/sector_chain_allocator_core_tb.sv]
`timescale 1ns / 100ps

module sector_chain_allocator_core_tb;
    import sca_pkg::*;

    // request codes the block must treat as no-ops
    localparam logic [2:0] REQ_RSVD_A = 3'd5;
    localparam logic [2:0] REQ_RSVD_B = 3'd6;
    localparam logic [2:0] REQ_RSVD_C = 3'd7;

    localparam logic [COUNT_W-1:0] NIL = '1;   // chain end / empty list
    localparam int unsigned HELD_MAX = 64;

    typedef struct packed {
        logic [SECTOR_W-1:0] sec;
        logic                is_end;
        logic [1:0]          st;
        logic [COUNT_W-1:0]  left;
    } t_chain_result;

    typedef enum logic [1:0] {ROW_REQ, ROW_CHK, ROW_CFG} t_row_kind;

    // config rows: sec = total_sectors, e_sec = map_sectors
    typedef struct packed {
        t_row_kind           kind;
        logic [2:0]          req;
        logic [SECTOR_W-1:0] sec;
        logic [SECTOR_W-1:0] e_sec;
        logic                e_end;
        logic [1:0]          e_st;
        logic [COUNT_W-1:0]  e_left;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [2:0]          i_req_type = REQ_FORMAT;
    logic [SECTOR_W-1:0] i_sector = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [SECTOR_W-1:0] o_result_sector;
    logic                o_is_end;
    logic [1:0]          o_status;
    logic [COUNT_W-1:0]  o_free_left;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    sector_chain_allocator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_sector       (i_sector),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_sector(o_result_sector),
        .o_is_end       (o_is_end),
        .o_status       (o_status),
        .o_free_left    (o_free_left),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // allocation table mirror
    logic [COUNT_W-1:0]  link_mem [0:DEFAULT_ENTRIES-1];
    bit                  link_set [0:DEFAULT_ENTRIES-1];
    logic [COUNT_W-1:0]  chain_head = NIL;
    logic [COUNT_W-1:0]  free_cnt = '0;
    logic [TOTAL_W-1:0]  cfg_total = TOTAL_RESET;
    logic [MAP_W-1:0]    cfg_map = MAP_RESET;
    int unsigned         held_q [$];      // table indexes handed out, candidates to free
    t_chain_result       result_q [$];
    t_chain_result       want;
    int unsigned         err_cnt = 0;
    bit                  calm = 1'b0;

    function automatic int unsigned sector_base();
        return cfg_map + 32'd2;
    endfunction

    function automatic int unsigned data_len();
        int unsigned b, d;
        b = sector_base();
        d = (cfg_total > b) ? cfg_total - b : 0;
        return (d > DEFAULT_ENTRIES) ? DEFAULT_ENTRIES : d;
    endfunction

    function automatic t_chain_result chain_step(input logic [2:0] req,
                                                 input logic [SECTOR_W-1:0] sec);
        t_chain_result r;
        int unsigned b, d, idx, i;
        r = '0;
        r.st = ST_OK;
        b = sector_base();
        d = data_len();
        if (req == REQ_FORMAT) begin
            for (i = 0; i < d; i++) begin
                link_mem[i] = (i + 1 < d) ? COUNT_W'(i + 1) : NIL;
                link_set[i] = 1'b1;
            end
            chain_head = (d > 0) ? '0 : NIL;
            free_cnt = (d > COUNT_MAX) ? COUNT_MAX : COUNT_W'(d);
            held_q.delete();
        end else if (req == REQ_ALLOCATE) begin
            if (chain_head >= DEFAULT_ENTRIES) begin
                r.st = ST_NO_FREE;
                r.is_end = 1'b1;
            end else begin
                idx = chain_head;
                chain_head = link_mem[idx];
                link_mem[idx] = NIL;
                if (free_cnt != 0) free_cnt--;
                r.sec = SECTOR_W'(idx + b);
                held_q.push_back(idx);
                if (held_q.size() > HELD_MAX) void'(held_q.pop_front());
            end
        end else if (req == REQ_FREE || req == REQ_NEXT || req == REQ_MARK_END) begin
            if (sec < b || sec - b >= d) begin
                r.st = ST_RANGE;
                r.is_end = 1'b1;
            end else begin
                idx = sec - b;
                if (req == REQ_FREE) begin
                    link_mem[idx] = chain_head;
                    link_set[idx] = 1'b1;
                    chain_head = COUNT_W'(idx);
                    if (free_cnt != COUNT_MAX) free_cnt++;
                end else if (req == REQ_NEXT) begin
                    if (link_mem[idx] == NIL) r.is_end = 1'b1;
                    else r.sec = SECTOR_W'(link_mem[idx] + b);
                end else begin
                    link_mem[idx] = NIL;
                    link_set[idx] = 1'b1;
                end
            end
        end
        r.left = free_cnt;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (result_q.size() == 0) begin
                flag_error($sformatf("unexpected result sector=%0d end=%0b st=%0d left=%0d",
                                     o_result_sector, o_is_end, o_status, o_free_left));
            end else begin
                want = result_q.pop_front();
                if (o_result_sector !== want.sec || o_is_end !== want.is_end ||
                    o_status !== want.st || o_free_left !== want.left)
                    flag_error($sformatf({"exp sector=%0d end=%0b st=%0d left=%0d, ",
                                          "got sector=%0d end=%0b st=%0d left=%0d"},
                                         want.sec, want.is_end, want.st, want.left,
                                         o_result_sector, o_is_end, o_status,
                                         o_free_left));
            end
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 7);
    end

    task automatic send_req(input logic [2:0] req, input logic [SECTOR_W-1:0] sec,
                            input bit typed, input t_chain_result typed_res);
        t_chain_result got;
        if (!calm && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_sector <= sec;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        got = chain_step(req, sec);
        result_q.push_back(typed ? typed_res : got);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves psel high; the caller closes the transfer
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic set_layout(input logic [TOTAL_W-1:0] total, input logic [MAP_W-1:0] map);
        wait_drained();
        reg_write({REG_TOTAL, 2'b00}, 32'(total));
        reg_write({REG_MAP, 2'b00}, 32'(map));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_total = total;
        cfg_map = map;
        held_q.delete();
    endtask

    task automatic random_req();
        int unsigned b, d, pick, rel, k;
        logic [2:0] req;
        logic [SECTOR_W-1:0] sec;
        if ($urandom_range(99) == 0) wait_drained();
        b = sector_base();
        d = data_len();
        pick = $urandom_range(99);
        sec = SECTOR_W'($urandom);
        if (pick < 35) begin
            req = REQ_ALLOCATE;
        end else if (pick < 85 && d != 0) begin
            rel = $urandom_range(d - 1);
            if (pick < 60) begin
                req = REQ_FREE;
                if (held_q.size() != 0 && $urandom_range(9) < 7) begin
                    k = $urandom_range(held_q.size() - 1);
                    if (held_q[k] < d) rel = held_q[k];
                    held_q.delete(k);
                end
            end else if (pick < 78 && link_set[rel]) begin
                req = REQ_NEXT;   // only entries that hold a defined link
            end else begin
                req = REQ_MARK_END;
            end
            sec = SECTOR_W'(b + rel);
        end else if (pick < 88) begin
            req = (d <= 256) ? REQ_FORMAT : REQ_ALLOCATE;
        end else if (pick < 96) begin
            req = (pick < 91) ? REQ_FREE : (pick < 94) ? REQ_NEXT : REQ_MARK_END;
            case ($urandom_range(2))
                0: sec = SECTOR_W'(b - 1);
                1: sec = SECTOR_W'(b + d);
                default: if (sec >= b && sec - b < d) sec = SECTOR_W'(b + d);
            endcase
        end else begin
            case ($urandom_range(2))
                0: req = REQ_RSVD_A;
                1: req = REQ_RSVD_B;
                default: req = REQ_RSVD_C;
            endcase
        end
        send_req(req, sec, 1'b0, '0);
    endtask

    // reset layout: base 34, 4096 data sectors
    t_dir_row dir_tab [0:31] = '{
        '{ROW_CHK, REQ_ALLOCATE, 20'd0,      20'd0,  1'b1, ST_NO_FREE, 13'd0},
        '{ROW_CHK, REQ_NEXT,     20'd0,      20'd0,  1'b1, ST_RANGE,   13'd0},
        '{ROW_CHK, REQ_FREE,     20'hFFFFF,  20'd0,  1'b1, ST_RANGE,   13'd0},
        '{ROW_CHK, REQ_MARK_END, 20'd33,     20'd0,  1'b1, ST_RANGE,   13'd0},
        '{ROW_CHK, REQ_RSVD_A,   20'd0,      20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_CHK, REQ_RSVD_B,   20'hFFFFF,  20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_CHK, REQ_RSVD_C,   20'hAAAAA,  20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_CHK, REQ_FORMAT,   20'd0,      20'd0,  1'b0, ST_OK,      13'd4096},
        '{ROW_CHK, REQ_NEXT,     20'd34,     20'd35, 1'b0, ST_OK,      13'd4096},
        '{ROW_CHK, REQ_NEXT,     20'd4129,   20'd0,  1'b1, ST_OK,      13'd4096},
        '{ROW_CHK, REQ_NEXT,     20'd4130,   20'd0,  1'b1, ST_RANGE,   13'd4096},
        '{ROW_CHK, REQ_ALLOCATE, 20'd0,      20'd34, 1'b0, ST_OK,      13'd4095},
        '{ROW_CHK, REQ_NEXT,     20'd34,     20'd0,  1'b1, ST_OK,      13'd4095},
        '{ROW_CHK, REQ_FREE,     20'd34,     20'd0,  1'b0, ST_OK,      13'd4096},
        '{ROW_CHK, REQ_MARK_END, 20'd35,     20'd0,  1'b0, ST_OK,      13'd4096},
        '{ROW_CHK, REQ_ALLOCATE, 20'd0,      20'd34, 1'b0, ST_OK,      13'd4095},
        '{ROW_CHK, REQ_ALLOCATE, 20'd0,      20'd35, 1'b0, ST_OK,      13'd4094},
        '{ROW_CHK, REQ_ALLOCATE, 20'd0,      20'd0,  1'b1, ST_NO_FREE, 13'd4094},
        // double free builds a self loop
        '{ROW_REQ, REQ_FREE,     20'd4129,   20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_REQ, REQ_FREE,     20'd4129,   20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_REQ, REQ_NEXT,     20'd4129,   20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_REQ, REQ_ALLOCATE, 20'd0,      20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_REQ, REQ_ALLOCATE, 20'd0,      20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_REQ, REQ_ALLOCATE, 20'd0,      20'd0,  1'b0, ST_OK,      13'd0},
        // no data sectors at all
        '{ROW_CFG, REQ_FORMAT,   20'd3,      20'd1,  1'b0, ST_OK,      13'd0},
        '{ROW_CHK, REQ_FORMAT,   20'd0,      20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_CHK, REQ_ALLOCATE, 20'd0,      20'd0,  1'b1, ST_NO_FREE, 13'd0},
        '{ROW_CHK, REQ_NEXT,     20'd3,      20'd0,  1'b1, ST_RANGE,   13'd0},
        // widest layout, clipped to the table size
        '{ROW_CFG, REQ_FORMAT,   20'hFFFFF,  20'd8192, 1'b0, ST_OK,    13'd0},
        '{ROW_REQ, REQ_NEXT,     20'd8194,   20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_REQ, REQ_FREE,     20'd12289,  20'd0,  1'b0, ST_OK,      13'd0},
        '{ROW_REQ, REQ_ALLOCATE, 20'd0,      20'd0,  1'b0, ST_OK,      13'd0}
    };

    initial begin
        int unsigned ph, m, t;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[n]) begin
            case (dir_tab[n].kind)
                ROW_CFG: set_layout(TOTAL_W'(dir_tab[n].sec), MAP_W'(dir_tab[n].e_sec));
                ROW_CHK: send_req(dir_tab[n].req, dir_tab[n].sec, 1'b1,
                                  '{sec: dir_tab[n].e_sec, is_end: dir_tab[n].e_end,
                                    st: dir_tab[n].e_st, left: dir_tab[n].e_left});
                default: send_req(dir_tab[n].req, dir_tab[n].sec, 1'b0, '0);
            endcase
        end

        for (ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_layout(20'hFFFFF, 14'd1);
                1: set_layout(20'hFFFFF, 14'd8192);
                2: set_layout(20'd3, 14'd8192);
                default: begin
                    m = $urandom_range(1, 8192);
                    if ($urandom_range(9) == 0) t = $urandom_range(3, m + 2);
                    else t = m + 2 + $urandom_range(1, 40);
                    set_layout(TOTAL_W'(t), MAP_W'(m));
                end
            endcase
            calm <= (ph == 4);
            if (ph < 2 || $urandom_range(9) != 0)
                send_req(REQ_FORMAT, SECTOR_W'($urandom), 1'b0, '0);
            repeat (100) random_req();
        end
        calm <= 1'b0;

        // burst of frees on the widest layout, then take a few back
        set_layout(20'hFFFFF, 14'd1);
        send_req(REQ_FORMAT, '0, 1'b0, '0);
        repeat (40)
            send_req(REQ_FREE, SECTOR_W'(sector_base() + $urandom_range(data_len() - 1)),
                     1'b0, '0);
        repeat (10) send_req(REQ_ALLOCATE, SECTOR_W'($urandom), 1'b0, '0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS sector_chain_allocator_core");
        end else begin
            $display("FAIL sector_chain_allocator_core");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL sector_chain_allocator_core");
        $finish;
    end

endmodule
